// ----- src/aes_pkg.sv -----
`default_nettype none
package aes_pkg;
   typedef logic [127:0] block_type;

   localparam int NumRounds = 10;
   localparam int CsrIdxWidth = 1;
   localparam logic [CsrIdxWidth-1:0] CsrKeyUpper = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLower = 1'b1;

   localparam logic [7:0] SboxTable [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RconTable [NumRounds] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // byte i of the state sits at bits 127-8i .. 120-8i
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      get_byte = b[127-8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction
endpackage
`default_nettype wire

// ----- src/aes_stream_if.sv -----
`default_nettype none
interface aes_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] upper;
   logic [63:0] lower;
   modport source (output valid, output upper, output lower, input ready);
   modport sink (input valid, input upper, input lower, output ready);
endinterface
`default_nettype wire

// ----- src/aes_round.sv -----
`default_nettype none
module aes_round import aes_pkg::*; #(
   parameter int Round = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      in_valid,
   input  wire block_type in_state,
   input  wire block_type in_key,
   output logic           out_valid,
   output block_type      out_state,
   output block_type      out_key
);
   block_type state_ff, key_ff, state_in, key_in;
   logic      valid_ff;

   always_comb begin
      logic [7:0] t [16];
      logic [7:0] m [16];
      logic [7:0] k [16];
      logic [7:0] w [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r+4*c] = SboxTable[get_byte(in_state, r + 4*((c + r) % 4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            m[r+4*c] = xtime(t[r+4*c]) ^ xtime(t[(r+1)%4+4*c]) ^ t[(r+1)%4+4*c]
                     ^ t[(r+2)%4+4*c] ^ t[(r+3)%4+4*c];
         end
      end
      w[0] = SboxTable[get_byte(in_key, 13)] ^ RconTable[Round];
      w[1] = SboxTable[get_byte(in_key, 14)];
      w[2] = SboxTable[get_byte(in_key, 15)];
      w[3] = SboxTable[get_byte(in_key, 12)];
      for (int i = 0; i < 4; i++) k[i] = get_byte(in_key, i) ^ w[i];
      for (int i = 4; i < 16; i++) k[i] = get_byte(in_key, i) ^ k[i-4];
      for (int i = 0; i < 16; i++) begin
         key_in[127-8*i -: 8] = k[i];
         state_in[127-8*i -: 8] = ((Round == NumRounds - 1) ? t[i] : m[i]) ^ k[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         state_ff <= state_in;
         key_ff   <= key_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key   = key_ff;
endmodule
`default_nettype wire

// ----- src/aes128_block_encrypt.sv -----
`default_nettype none
// AES-128 encryption pipeline (FIPS-197). Write the key through csr_ (index 0 holds key
// bytes 0..7, index 1 bytes 8..15, byte 0 most significant) while no request is in
// flight. One request enters every cycle while the output is not stalled. Each round is one
// register stage, and an input stage for the initial AddRoundKey comes before them, so
// there are eleven stages in all. A result passes the input stage and then each round
// stage in order, and is presented from the last one. The round keys expand alongside the
// data in each stage. A stall on rsp_ freezes the whole pipeline, so nothing is dropped.
module aes128_block_encrypt import aes_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [63:0] csr_data,
   aes_stream_if.sink       req,
   aes_stream_if.source     rsp
);
   logic [63:0] key_upper_ff, key_lower_ff;
   logic        advance;
   logic        v0_ff;
   block_type   s0_ff, k0_ff;
   logic        vld [NumRounds+1];
   block_type   st  [NumRounds+1];
   block_type   ky  [NumRounds+1];

   // advance when the output slot is empty or being taken
   assign advance   = !vld[NumRounds] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
         v0_ff        <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CsrKeyUpper: key_upper_ff <= csr_data;
               CsrKeyLower: key_lower_ff <= csr_data;
               default: ;
            endcase
         end
         if (advance) v0_ff <= req.valid;
      end
      // initial AddRoundKey
      if (advance) begin
         s0_ff <= {req.upper, req.lower} ^ {key_upper_ff, key_lower_ff};
         k0_ff <= {key_upper_ff, key_lower_ff};
      end
   end

   assign vld[0] = v0_ff;
   assign st[0]  = s0_ff;
   assign ky[0]  = k0_ff;

   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      aes_round #(.Round(r)) u_round (
         .clock, .reset, .advance,
         .in_valid(vld[r]), .in_state(st[r]), .in_key(ky[r]),
         .out_valid(vld[r+1]), .out_state(st[r+1]), .out_key(ky[r+1])
      );
   end

   assign rsp.valid = vld[NumRounds];
   assign rsp.upper = st[NumRounds][127:64];
   assign rsp.lower = st[NumRounds][63:0];

`ifndef SYNTHESIS
   // hold the result while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.upper) && $stable(rsp.lower))
      else $error("result changed under stall");
   // input is taken only when pipeline moves
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("ready does not follow output slot");
   // an accepted request reaches the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v0_ff)
      else $error("request lost at input stage");
`endif
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
module testbench import aes_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] upper;
      logic [63:0] lower;
   } half_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = CsrKeyUpper;
   logic [63:0] csr_data = '0;

   aes_stream_if req_if ();
   aes_stream_if rsp_if ();

   aes128_block_encrypt i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_if.sink),
      .rsp       (rsp_if.source)
   );

   always #5 clock = ~clock;

   // key as the block sees it; the model keeps its own copy
   logic [63:0] key_hi = '0;
   logic [63:0] key_lo = '0;

   half_pair_type pending_blocks[$];
   half_pair_type expected_cipher[$];
   int  errors = 0;
   int  blocks_sent = 0;
   int  blocks_checked = 0;
   int  keys_used = 1;
   bit  sender_hold = 1'b0;
   bit  receiver_hold = 1'b0;
   int  long_stall_at = 400;

   // state byte i lives at bits 127-8i
   function automatic logic [7:0] mul_gf(input logic [7:0] a, input logic [7:0] k);
      logic [7:0] r;
      r = '0;
      for (int b = 0; b < 8; b++) begin
         if (k[b]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   function automatic half_pair_type encrypt_block(input half_pair_type plain,
                                                   input logic [63:0] k_hi,
                                                   input logic [63:0] k_lo);
      logic [7:0] st[16];
      logic [7:0] tmp[16];
      logic [7:0] rk[16];
      logic [7:0] rot[4];
      logic [7:0] rcon;
      logic [127:0] flat;
      logic [127:0] kflat;
      flat = {plain.upper, plain.lower};
      kflat = {k_hi, k_lo};
      rcon = 8'h01;
      for (int i = 0; i < 16; i++) begin
         st[i] = flat[127-8*i -: 8] ^ kflat[127-8*i -: 8];
         rk[i] = kflat[127-8*i -: 8];
      end
      for (int rnd = 0; rnd < 10; rnd++) begin
         // substitute and shift rows together
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               tmp[r + 4*c] = SboxTable[st[r + 4*((c + r) % 4)]];
         if (rnd < 9) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  st[r + 4*c] = mul_gf(tmp[r + 4*c], 8'd2)
                              ^ mul_gf(tmp[(r + 1) % 4 + 4*c], 8'd3)
                              ^ tmp[(r + 2) % 4 + 4*c] ^ tmp[(r + 3) % 4 + 4*c];
         end else begin
            st = tmp;
         end
         rot[0] = SboxTable[rk[13]] ^ rcon;
         rot[1] = SboxTable[rk[14]];
         rot[2] = SboxTable[rk[15]];
         rot[3] = SboxTable[rk[12]];
         for (int i = 0; i < 4; i++) rk[i] ^= rot[i];
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
         rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
         for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      end
      for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = st[i];
      return '{upper: flat[127:64], lower: flat[63:0]};
   endfunction

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // driver: offer the head of the queue, move on after acceptance, change at negedge
   int send_gap = 0;
   int accepts_seen = 0;
   int accepts_done = 0;

   always @(negedge clock) begin
      bit taken;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.upper <= '0;
         req_if.lower <= '0;
      end else begin
         taken = (accepts_seen != accepts_done);
         accepts_done = accepts_seen;
         if (taken) send_gap = gap_length();
         if (req_if.valid && !taken) begin
            // hold the offer until it is taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_blocks.size() > 0 && !sender_hold) begin
            req_if.valid <= 1'b1;
            req_if.upper <= pending_blocks[0].upper;
            req_if.lower <= pending_blocks[0].lower;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // predict at the accepting edge, with the key in force then
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         expected_cipher.push_back(encrypt_block('{upper: req_if.upper, lower: req_if.lower},
                                                 key_hi, key_lo));
         void'(pending_blocks.pop_front());
         blocks_sent++;
         accepts_seen++;
      end
   end

   // receiver backpressure: random gaps, plus one long hold counted here
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (blocks_sent == long_stall_at && !receiver_hold) begin
            receiver_hold = 1'b1;
            stall_left = 80;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (gap_length() == 0) || ($urandom_range(0, 1) == 1);
         end
      end
   end

   // monitor: compare each accepted result against the oldest prediction
   always @(posedge clock) begin
      half_pair_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_cipher.size() == 0) begin
            $error("unexpected result %h_%h", rsp_if.upper, rsp_if.lower);
            errors++;
         end else begin
            want = expected_cipher.pop_front();
            if (rsp_if.upper !== want.upper) begin
               $error("cipher_upper: expected %h actual %h", want.upper, rsp_if.upper);
               errors++;
            end
            if (rsp_if.lower !== want.lower) begin
               $error("cipher_lower: expected %h actual %h", want.lower, rsp_if.lower);
               errors++;
            end
            blocks_checked++;
         end
      end
   end

   task automatic wait_drained();
      while (pending_blocks.size() > 0 || expected_cipher.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // write one key register at an idle moment
   task automatic write_key(input logic [CsrIdxWidth-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CsrKeyUpper) key_hi = value;
      else key_lo = value;
   endtask

   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
      write_key(CsrKeyUpper, hi);
      write_key(CsrKeyLower, lo);
      keys_used++;
   endtask

   task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
      pending_blocks.push_back('{upper: hi, lower: lo});
   endtask

   initial begin
      logic [63:0] sel;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero key straight from reset, edge patterns
      queue_block('0, '0);
      queue_block('1, '1);
      queue_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      wait_drained();

      // FIPS-197 appendix vector
      load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
      queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      queue_block('0, '1);
      queue_block('1, '0);
      for (int i = 0; i < 8; i++) queue_block(64'h1 << (8*i), 64'h80 << (8*i));
      wait_drained();

      load_key('1, '1);
      queue_block('0, '0);
      queue_block('1, '1);
      queue_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      wait_drained();

      // random phases; the long output hold falls inside the second one
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) load_key('0, '0);
         else load_key(rand64(), rand64());
         for (int n = 0; n < 300; n++) begin
            sel = rand64();
            case ($urandom_range(0, 9))
               0: queue_block('0, sel);
               1: queue_block(sel, '1);
               default: queue_block(sel, rand64());
            endcase
         end
         if (phase == 2) begin
            // sender pauses mid-phase until everything in flight is back
            while (pending_blocks.size() > 150) @(posedge clock);
            sender_hold = 1'b1;
            while (expected_cipher.size() > 0 || req_if.valid) @(posedge clock);
            sender_hold = 1'b0;
         end
         wait_drained();
      end

      $display("Covered %0d blocks under %0d keys, incl. the FIPS-197 vector and all-ones keys.",
               blocks_checked, keys_used);
      $display("Output held off for a long stretch once; input paused until drained once.");
      if (errors == 0) begin
         $display("** aes128_block_encrypt: PASSED **");
      end else begin
         $display("** aes128_block_encrypt: FAILED **");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("** aes128_block_encrypt: FAILED **");
      $finish;
   end
endmodule
